// File: rtl/tspes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tspes_pkg
// Shared types, constants and the fixed PAT/PMT table for the PES packetizer.
// ----------------------------------------------------------------------------
package tspes_pkg;

    localparam int PacketBytes = 188;
    localparam int TableBytes  = 2 * PacketBytes;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [1:0] CMD_TABLES  = 2'd2;

    localparam logic [32:0] DELAY_RESET = 33'd63000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_HDR,
        ST_PAY,
        ST_TBL
    } state_t;

    typedef struct packed {
        logic latch;
        logic hold;
        logic plan;
        logic hdr_push;
        logic pay_push;
        logic pay_held;
        logic tbl_start;
        logic tbl_push;
    } ctl_t;

    typedef struct packed {
        logic stall;
        logic rem_zero;
        logic pos_zero;
        logic hdr_last;
        logic tbl_last;
    } sts_t;

    localparam logic [7:0] PAT [21] = '{
        8'h47, 8'h40, 8'h00, 8'h10, 8'h00,
        8'h00, 8'hb0, 8'h0d, 8'h00, 8'h01, 8'hc1, 8'h00, 8'h00,
        8'h00, 8'h01, 8'hf0, 8'h01,
        8'h2e, 8'h70, 8'h19, 8'h05
    };
    localparam logic [7:0] PMT [31] = '{
        8'h47, 8'h50, 8'h01, 8'h10, 8'h00,
        8'h02, 8'hb0, 8'h17, 8'h00, 8'h01, 8'hc1, 8'h00, 8'h00,
        8'he1, 8'h00, 8'hf0, 8'h00,
        8'h1b, 8'he1, 8'h00, 8'hf0, 8'h00,
        8'h0f, 8'he1, 8'h01, 8'hf0, 8'h00,
        8'h2f, 8'h44, 8'hb9, 8'h9b
    };

    // byte idx of the PAT packet followed by the PMT packet, 0xff stuffed
    function automatic logic [7:0] table_byte(input logic [8:0] idx);
        logic [8:0] i;
        logic [7:0] b;
        b = 8'hff;
        if (idx < 9'(PacketBytes)) begin
            if (idx < 9'd21) b = PAT[idx[4:0]];
        end else begin
            i = idx - 9'(PacketBytes);
            if (i < 9'd31) b = PMT[i[4:0]];
        end
        return b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/tspes_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tspes_ctrl
// Sequencer: decodes commands and steps header, payload and table bursts.
// ----------------------------------------------------------------------------
module tspes_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [1:0]    cmd,
    input  tspes_pkg::sts_t    sts,
    output tspes_pkg::ctl_t    ctl
);

    tspes_pkg::state_t state_reg, state_next;
    logic fire;

    assign fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= tspes_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tspes_pkg::ST_IDLE: begin
                if (fire) begin
                    if (cmd == tspes_pkg::CMD_PAYLOAD && !sts.rem_zero && sts.pos_zero)
                        state_next = tspes_pkg::ST_PLAN;
                    else if (cmd == tspes_pkg::CMD_TABLES && sts.rem_zero)
                        state_next = tspes_pkg::ST_TBL;
                end
            end
            tspes_pkg::ST_PLAN: state_next = tspes_pkg::ST_HDR;
            tspes_pkg::ST_HDR:
                if (!sts.stall && sts.hdr_last) state_next = tspes_pkg::ST_PAY;
            tspes_pkg::ST_PAY:
                if (!sts.stall) state_next = tspes_pkg::ST_IDLE;
            tspes_pkg::ST_TBL:
                if (!sts.stall && sts.tbl_last) state_next = tspes_pkg::ST_IDLE;
            default: state_next = tspes_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            tspes_pkg::ST_IDLE: begin
                s_tready = !sts.stall;
                if (fire) begin
                    case (cmd)
                        tspes_pkg::CMD_START: ctl.latch = 1'b1;
                        tspes_pkg::CMD_PAYLOAD: begin
                            if (!sts.rem_zero) begin
                                if (sts.pos_zero) ctl.hold = 1'b1;
                                else              ctl.pay_push = 1'b1;
                            end
                        end
                        tspes_pkg::CMD_TABLES: ctl.tbl_start = sts.rem_zero;
                        default: ;
                    endcase
                end
            end
            tspes_pkg::ST_PLAN: ctl.plan = 1'b1;
            tspes_pkg::ST_HDR:  ctl.hdr_push = !sts.stall;
            tspes_pkg::ST_PAY: begin
                ctl.pay_push = !sts.stall;
                ctl.pay_held = 1'b1;
            end
            tspes_pkg::ST_TBL:  ctl.tbl_push = !sts.stall;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/tspes_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tspes_datapath
// Frame state, header layout, byte generation, word packing, output register.
// ----------------------------------------------------------------------------
module tspes_datapath (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  tspes_pkg::ctl_t    ctl,
    output tspes_pkg::sts_t    sts,
    input  wire logic [32:0]   delay,
    input  wire logic          in_slot,
    input  wire logic [12:0]   in_pid,
    input  wire logic [7:0]    in_sid,
    input  wire logic          in_key,
    input  wire logic [32:0]   in_pts,
    input  wire logic [32:0]   in_dts,
    input  wire logic [23:0]   in_len,
    input  wire logic [7:0]    in_byte,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [71:0]        m_tdata,
    output logic               m_tlast
);

    // frame state
    logic [3:0]  cc_reg [2];
    logic [23:0] rem_reg;
    logic [7:0]  pos_reg;
    logic        first_reg;
    logic [32:0] pts_reg, dts_reg;
    logic [12:0] pid_reg;
    logic [7:0]  sid_reg;
    logic        key_reg, slot_reg;
    logic [7:0]  held_reg;
    logic [8:0]  idx_reg;

    // header layout, fixed at plan time
    logic        hfirst_reg, keyaf_reg, hasaf_reg, two_reg;
    logic [7:0]  aflen_reg, pesoff_reg, n_reg;
    logic [3:0]  cc_used_reg;
    logic [32:0] pcr_reg, ptsd_reg, dtsd_reg;
    logic [15:0] ps_reg;

    // packing and output
    logic [63:0] pack_reg;
    logic [3:0]  cnt_reg;
    logic        ov_reg, olast_reg;
    logic [63:0] oword_reg;
    logic [3:0]  ocnt_reg;

    // plan arithmetic
    logic        p_key, p_two, p_hasaf;
    logic [4:0]  p_peslen;
    logic [7:0]  p_fixed, p_body, p_stuff, p_aflen, p_n;
    logic [3:0]  p_hs, p_cc;
    logic [24:0] p_ps;

    always_comb begin
        p_key    = key_reg && first_reg;
        p_two    = pts_reg != dts_reg;
        p_hs     = p_two ? 4'd10 : 4'd5;
        p_peslen = first_reg ? (p_two ? 5'd19 : 5'd14) : 5'd0;
        p_fixed  = 8'd4 + (p_key ? 8'd8 : 8'd0) + {3'b0, p_peslen};
        p_body   = 8'(tspes_pkg::PacketBytes) - p_fixed;
        p_stuff  = ({16'b0, p_body} > rem_reg) ? p_body - rem_reg[7:0] : 8'd0;
        p_hasaf  = p_key || (p_stuff != 8'd0);
        p_aflen  = p_key ? 8'd7 + p_stuff : (p_stuff != 8'd0 ? p_stuff - 8'd1 : 8'd0);
        p_n      = 8'd4 + (p_hasaf ? 8'd1 + p_aflen : 8'd0) + {3'b0, p_peslen};
        p_ps     = {1'b0, rem_reg} + {21'b0, p_hs} + 25'd3;
        p_cc     = cc_reg[slot_reg] + 4'd1;
    end

    // header byte at the current index
    logic [7:0] i8, a8, p8, hbyte;
    logic [32:0] sv;
    logic [3:0]  fb;
    always_comb begin
        i8 = idx_reg[7:0];
        a8 = i8 - 8'd5;
        p8 = i8 - pesoff_reg;
        sv = (p8 < 8'd14) ? ptsd_reg : dtsd_reg;
        fb = (p8 < 8'd14) ? (two_reg ? 4'd3 : 4'd2) : 4'd1;
        hbyte = 8'hff;
        if (i8 == 8'd0)      hbyte = 8'h47;
        else if (i8 == 8'd1) hbyte = {1'b0, hfirst_reg, 1'b0, pid_reg[12:8]};
        else if (i8 == 8'd2) hbyte = pid_reg[7:0];
        else if (i8 == 8'd3) hbyte = {2'b00, hasaf_reg, 1'b1, cc_used_reg};
        else if (hasaf_reg && i8 == 8'd4) hbyte = aflen_reg;
        else if (hasaf_reg && i8 < pesoff_reg) begin
            if (keyaf_reg) begin
                case (a8)
                    8'd0: hbyte = 8'h50;
                    8'd1: hbyte = pcr_reg[32:25];
                    8'd2: hbyte = pcr_reg[24:17];
                    8'd3: hbyte = pcr_reg[16:9];
                    8'd4: hbyte = pcr_reg[8:1];
                    8'd5: hbyte = {pcr_reg[0], 7'h7e};
                    8'd6: hbyte = 8'h00;
                    default: hbyte = 8'hff;
                endcase
            end else begin
                hbyte = (a8 == 8'd0) ? 8'h00 : 8'hff;
            end
        end else begin
            case (p8)
                8'd0, 8'd1: hbyte = 8'h00;
                8'd2:  hbyte = 8'h01;
                8'd3:  hbyte = sid_reg;
                8'd4:  hbyte = ps_reg[15:8];
                8'd5:  hbyte = ps_reg[7:0];
                8'd6:  hbyte = 8'h80;
                8'd7:  hbyte = two_reg ? 8'hc0 : 8'h80;
                8'd8:  hbyte = two_reg ? 8'd10 : 8'd5;
                8'd9, 8'd14:  hbyte = {fb, sv[32:30], 1'b1};
                8'd10, 8'd15: hbyte = sv[29:22];
                8'd11, 8'd16: hbyte = {sv[21:15], 1'b1};
                8'd12, 8'd17: hbyte = sv[14:7];
                8'd13, 8'd18: hbyte = {sv[6:0], 1'b1};
                default: hbyte = 8'hff;
            endcase
        end
    end

    // byte push into the packer
    logic        push, plast, wdone, stall;
    logic [7:0]  pbyte;
    logic [63:0] pack_next;
    logic [3:0]  cnt_next;
    logic [5:0]  shamt;
    logic [8:0]  pos_inc;

    always_comb begin
        push  = ctl.hdr_push || ctl.pay_push || ctl.tbl_push;
        pbyte = 8'h00;
        plast = 1'b0;
        if (ctl.hdr_push) pbyte = hbyte;
        else if (ctl.tbl_push) begin
            pbyte = tspes_pkg::table_byte(idx_reg);
            plast = sts.tbl_last;
        end else if (ctl.pay_push) begin
            pbyte = ctl.pay_held ? held_reg : in_byte;
            plast = rem_reg == 24'd1;
        end
        pack_next = {pack_reg[55:0], pbyte};
        cnt_next  = cnt_reg + 4'd1;
        wdone     = push && (cnt_next == 4'd8 || plast);
        shamt     = {3'(4'd8 - cnt_next), 3'b000};
        stall     = ov_reg && !m_tready;
        pos_inc   = {1'b0, pos_reg} + 9'd1;
    end

    assign sts.stall    = stall;
    assign sts.rem_zero = rem_reg == 24'd0;
    assign sts.pos_zero = pos_reg == 8'd0;
    assign sts.hdr_last = idx_reg == {1'b0, n_reg - 8'd1};
    assign sts.tbl_last = idx_reg == 9'(tspes_pkg::TableBytes - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg[0] <= '0;
            cc_reg[1] <= '0;
            rem_reg   <= '0;
            pos_reg   <= '0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
            pack_reg  <= '0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (ctl.latch) begin
                rem_reg   <= in_len;
                pos_reg   <= '0;
                first_reg <= 1'b1;
                cnt_reg   <= '0;
                pack_reg  <= '0;
            end
            if (ctl.plan) begin
                cc_reg[slot_reg] <= p_cc;
                first_reg        <= 1'b0;
                pos_reg          <= p_n;
                idx_reg          <= '0;
            end
            if (ctl.tbl_start) idx_reg <= '0;
            if (ctl.hdr_push || ctl.tbl_push) idx_reg <= idx_reg + 9'd1;
            if (ctl.pay_push) begin
                rem_reg <= rem_reg - 24'd1;
                if (pos_inc >= 9'(tspes_pkg::PacketBytes) || rem_reg == 24'd1)
                    pos_reg <= '0;
                else
                    pos_reg <= pos_inc[7:0];
            end
            if (push) begin
                if (wdone) begin
                    pack_reg <= '0;
                    cnt_reg  <= '0;
                end else begin
                    pack_reg <= pack_next;
                    cnt_reg  <= cnt_next;
                end
            end
            if (wdone)         ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.latch) begin
            pts_reg  <= in_pts;
            dts_reg  <= in_dts;
            pid_reg  <= in_pid;
            sid_reg  <= in_sid;
            key_reg  <= in_key;
            slot_reg <= in_slot;
        end
        if (ctl.hold) held_reg <= in_byte;
        if (ctl.plan) begin
            hfirst_reg  <= first_reg;
            keyaf_reg   <= p_key;
            hasaf_reg   <= p_hasaf;
            two_reg     <= p_two;
            aflen_reg   <= p_aflen;
            pesoff_reg  <= 8'd4 + (p_hasaf ? 8'd1 + p_aflen : 8'd0);
            n_reg       <= p_n;
            cc_used_reg <= p_cc;
            pcr_reg     <= dts_reg - delay;
            ptsd_reg    <= pts_reg + delay;
            dtsd_reg    <= dts_reg + delay;
            ps_reg      <= (p_ps > 25'd65535) ? 16'd0 : p_ps[15:0];
        end
        if (wdone) begin
            oword_reg <= pack_next << shamt;
            ocnt_reg  <= cnt_next;
            olast_reg <= plast;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'b0, ocnt_reg, oword_reg};
    assign m_tlast  = olast_reg;

endmodule
`default_nettype wire

// File: rtl/ts_pes_packetizer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ts_pes_packetizer_core
// MPEG-2 transport stream PES packetizer with APB delay register.
// ----------------------------------------------------------------------------
// A start beat (tuser 0) latches a frame; a payload beat (tuser 1) is taken
// while the block is idle and not stalled. The first payload beat of each
// 188-byte packet is held through a planning state, then the header (4 to
// 187 bytes, emitted a byte per cycle unless stalled through the word
// packer), then the placing of the held byte; a table beat (tuser 2) keeps
// the block busy while it emits the 376 table bytes. Output words carry up
// to eight bytes, first byte in the top bits; stalls come only from m_tready.
module ts_pes_packetizer_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [0] stream_slot, [13:1] packet_id, [21:14] stream_code, [22] key_frame,
    // [55:23] frame_pts, [88:56] frame_dts, [112:89] frame_length,
    // [120:113] payload_byte
    input  wire logic [127:0] s_tdata,
    // [1:0] command
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [63:0] out_bytes, [67:64] byte_count
    output logic [71:0]       m_tdata,
    output logic              m_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [32:0]      delay_reg;
    tspes_pkg::ctl_t  ctl;
    tspes_pkg::sts_t  sts;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            delay_reg <= tspes_pkg::DELAY_RESET;
        else if (psel && penable && pwrite && paddr[3] == 1'b0)
            delay_reg <= pwdata[32:0];
    end

    assign prdata = (paddr[3] == 1'b0) ? {31'b0, delay_reg} : 64'b0;

    tspes_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (s_tuser),
        .sts      (sts),
        .ctl      (ctl)
    );

    tspes_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .sts      (sts),
        .delay    (delay_reg),
        .in_slot  (s_tdata[0]),
        .in_pid   (s_tdata[13:1]),
        .in_sid   (s_tdata[21:14]),
        .in_key   (s_tdata[22]),
        .in_pts   (s_tdata[55:23]),
        .in_dts   (s_tdata[88:56]),
        .in_len   (s_tdata[112:89]),
        .in_byte  (s_tdata[120:113]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
